[hw/rtl/rmwq_pkg.sv]
// Shared types, codes and defaults for the recursive mutex with wait queue.
`timescale 1ns / 1ps
package rmwq_pkg;

    localparam int THREAD_W        = 4;
    localparam int DEPTH_OUT_W     = 8;
    localparam int MAX_THREADS_DEF = 16;
    localparam int MAX_DEPTH_DEF   = 255;

    typedef enum logic [1:0] {
        CMD_LOCK    = 2'd0,
        CMD_TRYLOCK = 2'd1,
        CMD_UNLOCK  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ACQUIRED = 3'd0,
        ST_NESTED   = 3'd1,
        ST_BLOCKED  = 3'd2,
        ST_BUSY     = 3'd3,
        ST_NEST_REL = 3'd4,
        ST_HANDOVER = 3'd5,
        ST_FREED    = 3'd6,
        ST_ERROR    = 3'd7
    } status_t;

    // Queue control shared by every cell of the waiter chain
    typedef struct packed {
        logic                push;
        logic                pop;
        logic [THREAD_W-1:0] tid;
    } q_ctrl_t;

endpackage

[hw/rtl/rmwq_cell.sv]
// One slot of the waiter chain: holds a thread id, loads a push or shifts on a pop.
`timescale 1ns / 1ps
module rmwq_cell (
    input  logic                          aclk,
    input  rmwq_pkg::q_ctrl_t             ctrl,
    input  logic                          sel,
    input  logic [rmwq_pkg::THREAD_W-1:0] next_id,
    output logic [rmwq_pkg::THREAD_W-1:0] id_q
);
    import rmwq_pkg::*;

    logic [THREAD_W-1:0] id_reg;

    // shift towards the head on a pop, capture the new waiter when selected
    always_ff @(posedge aclk) begin
        if (ctrl.pop) begin
            id_reg <= next_id;
        end else if (ctrl.push && sel) begin
            id_reg <= ctrl.tid;
        end
    end

    assign id_q = id_reg;

endmodule

[hw/rtl/rmwq_chain.sv]
// Row of waiter cells forming the FIFO of blocked threads, head at cell 0.
`timescale 1ns / 1ps
module rmwq_chain #(
    parameter int DEPTH = rmwq_pkg::MAX_THREADS_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                          aclk,
    input  rmwq_pkg::q_ctrl_t             ctrl,
    input  logic [CNT_W-1:0]              wr_pos,
    output logic [rmwq_pkg::THREAD_W-1:0] head_id
);
    import rmwq_pkg::*;

    logic [THREAD_W-1:0] ids [DEPTH+1];

    // nothing beyond the tail: feed zero into the last cell
    assign ids[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        rmwq_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .sel     (wr_pos == CNT_W'(i)),
            .next_id (ids[i+1]),
            .id_q    (ids[i])
        );
    end

    assign head_id = ids[0];

endmodule

[hw/rtl/recursive_mutex_with_wait_queue_unit.sv]
// Top level of the recursive mutex with a FIFO of waiting threads.
//
// Usage:
//   s_ channel: one request per handshake, carrying a command (lock,
//   trylock, unlock) and the requesting thread id.
//   m_ channel: one result per request: status, woken thread, owner and
//   nesting depth as they stand after the request.
//   cfg channel: writes recursive_mode; always ready. Write only while idle.
// Result: registered, and shown in the cycle after the request is taken.
// Throughput: one request per cycle unless a result stalls on m_ready; the
//   state update is a compare and counter step, and the waiter chain shifts once per pop.
// Reset (aresetn low, synchronous): the mutex is free, depth and queue
//   count are zero, recursive_mode is 0, no result is pending.
// Stall: while a result waits and m_ready is low, s_ready is low; the
//   result register holds its contents until taken.
`timescale 1ns / 1ps
module recursive_mutex_with_wait_queue_unit #(
    parameter int MAX_THREADS = rmwq_pkg::MAX_THREADS_DEF,
    parameter int MAX_DEPTH   = rmwq_pkg::MAX_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_command,
    input  logic [rmwq_pkg::THREAD_W-1:0]    s_thread_id,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_status,
    output logic                             m_woken_valid,
    output logic [rmwq_pkg::THREAD_W-1:0]    m_woken_thread,
    output logic                             m_owner_valid,
    output logic [rmwq_pkg::THREAD_W-1:0]    m_owner_thread,
    output logic [rmwq_pkg::DEPTH_OUT_W-1:0] m_depth_now
);
    import rmwq_pkg::*;

    localparam int CNT_W   = $clog2(MAX_THREADS + 1);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    // mutex state
    logic                recursive_reg;
    logic                held_reg,  held_next;
    logic [THREAD_W-1:0] owner_reg, owner_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // result register
    logic                m_valid_reg;
    logic [2:0]          status_reg;
    logic                woken_valid_reg;
    logic [THREAD_W-1:0] woken_thread_reg;
    logic                owner_valid_reg;
    logic [THREAD_W-1:0] owner_thread_reg;
    logic [DEPTH_W-1:0]  depth_out_reg;

    status_t             status;
    logic                woke;
    logic [THREAD_W-1:0] head_id;
    q_ctrl_t             q_ctrl;
    logic                accept;
    logic [DEPTH_W+DEPTH_OUT_W-1:0] depth_ext;

    assign cfg_ready = 1'b1;
    // take a new request whenever the result register is empty or draining
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    rmwq_chain #(
        .DEPTH (MAX_THREADS),
        .CNT_W (CNT_W)
    ) u_chain (
        .aclk    (aclk),
        .ctrl    (q_ctrl),
        .wr_pos  (count_reg),
        .head_id (head_id)
    );

    // decode one request against the current state
    always_comb begin
        held_next  = held_reg;
        owner_next = owner_reg;
        depth_next = depth_reg;
        count_next = count_reg;
        status     = ST_ERROR;
        woke       = 1'b0;
        q_ctrl     = '{push: 1'b0, pop: 1'b0, tid: s_thread_id};
        unique case (s_command)
            CMD_LOCK, CMD_TRYLOCK: begin
                priority if (!held_reg) begin
                    held_next  = 1'b1;
                    owner_next = s_thread_id;
                    depth_next = '0;
                    status     = ST_ACQUIRED;
                end else if (owner_reg == s_thread_id) begin
                    priority if (!recursive_reg) begin
                        // relock without recursion: error for lock, plain fail for trylock
                        status = (s_command == CMD_LOCK) ? ST_ERROR : ST_BUSY;
                    end else if (depth_reg >= DEPTH_W'(MAX_DEPTH)) begin
                        status = ST_ERROR;
                    end else begin
                        depth_next = depth_reg + 1'b1;
                        status     = ST_NESTED;
                    end
                end else if (s_command == CMD_TRYLOCK) begin
                    status = ST_BUSY;
                end else if (count_reg >= CNT_W'(MAX_THREADS)) begin
                    status = ST_ERROR;
                end else begin
                    // queue the caller at the tail of the chain
                    q_ctrl.push = accept;
                    count_next  = count_reg + 1'b1;
                    status      = ST_BLOCKED;
                end
            end
            CMD_UNLOCK: begin
                priority if (!held_reg || owner_reg != s_thread_id) begin
                    status = ST_ERROR;
                end else if (depth_reg != '0) begin
                    depth_next = depth_reg - 1'b1;
                    status     = ST_NEST_REL;
                end else if (count_reg != '0) begin
                    // hand over to the oldest waiter and advance the chain
                    q_ctrl.pop = accept;
                    count_next = count_reg - 1'b1;
                    owner_next = head_id;
                    woke       = 1'b1;
                    status     = ST_HANDOVER;
                end else begin
                    held_next  = 1'b0;
                    owner_next = '0;
                    status     = ST_FREED;
                end
            end
            default: begin
                status = ST_ERROR;
            end
        endcase
    end

    // state and config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recursive_reg <= 1'b0;
            held_reg      <= 1'b0;
            owner_reg     <= '0;
            depth_reg     <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                recursive_reg <= cfg_data;
            end
            if (accept) begin
                held_reg    <= held_next;
                owner_reg   <= owner_next;
                depth_reg   <= depth_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: hold until the next request is taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg       <= status;
            woken_valid_reg  <= woke;
            woken_thread_reg <= woke ? head_id : '0;
            owner_valid_reg  <= held_next;
            owner_thread_reg <= held_next ? owner_next : '0;
            depth_out_reg    <= depth_next;
        end
    end

    // report only the low bits of the nesting depth
    assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_out_reg};

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_woken_valid  = woken_valid_reg;
    assign m_woken_thread = woken_thread_reg;
    assign m_owner_valid  = owner_valid_reg;
    assign m_owner_thread = owner_thread_reg;
    assign m_depth_now    = depth_ext[DEPTH_OUT_W-1:0];

endmodule

[hw/rtl/rmwq_checker.sv]
// Port-level checks for the recursive mutex unit, bound to its top level.
`timescale 1ns / 1ps
module rmwq_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [2:0]                       m_status,
    input logic                             m_woken_valid,
    input logic [rmwq_pkg::THREAD_W-1:0]    m_woken_thread,
    input logic                             m_owner_valid,
    input logic [rmwq_pkg::THREAD_W-1:0]    m_owner_thread,
    input logic [rmwq_pkg::DEPTH_OUT_W-1:0] m_depth_now
);
    import rmwq_pkg::*;

    // every request taken yields a result in the next cycle
    a_req_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("request taken without a result");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_owner_thread))
        else $error("stalled result changed");

    // a woken thread is the new owner of a handed-over mutex
    a_handover: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_woken_valid |-> m_status == ST_HANDOVER && m_owner_valid
            && m_owner_thread == m_woken_thread)
        else $error("wake-up inconsistent with handover");

    // a free mutex shows no owner and no nesting
    a_free_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_owner_valid |-> m_owner_thread == '0 && m_depth_now == '0
            && !m_woken_valid)
        else $error("free mutex reports owner or depth");

endmodule

bind recursive_mutex_with_wait_queue_unit rmwq_checker u_rmwq_checker (.*);

[dv/recursive_mutex_with_wait_queue_unit_tb.sv]
// Testbench for the recursive mutex unit: shadow mutex state, result scoreboard and request driver.
`timescale 1ns / 1ps
module recursive_mutex_with_wait_queue_unit_tb;
    import rmwq_pkg::*;

    // Command code outside the defined set; the block must answer it with an error
    localparam logic [1:0] CMD_BAD = 2'd3;
    // Generous ceiling: a few times the slowest legal run of every request
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // Mix of commands for one random phase
    typedef enum int {
        MIX_EVEN,
        MIX_LOCKS,
        MIX_UNLOCKS
    } mix_t;

    // One result as seen on the m_ channel
    typedef struct packed {
        status_t             status;
        logic                woken_valid;
        logic [THREAD_W-1:0] woken_thread;
        logic                owner_valid;
        logic [THREAD_W-1:0] owner_thread;
        logic [7:0]          depth_now;
    } mutex_result_t;

    // Shadow copy of the mutex plus the queue of results still owed by the block
    class mutex_shadow;
        bit                  recursive;
        bit                  held;
        logic [THREAD_W-1:0] owner;
        logic [7:0]          depth;
        logic [THREAD_W-1:0] waiters [MAX_THREADS_DEF];
        int unsigned         head;
        int unsigned         count;
        mutex_result_t       pending_results [$];
        int unsigned         failures;

        function status_t grab(logic [THREAD_W-1:0] tid, bit may_block);
            if (!held) begin
                held  = 1'b1;
                owner = tid;
                depth = '0;
                return ST_ACQUIRED;
            end
            if (owner == tid) begin
                if (!recursive)
                    return may_block ? ST_ERROR : ST_BUSY;
                if (depth >= MAX_DEPTH_DEF)
                    return ST_ERROR;
                depth++;
                return ST_NESTED;
            end
            if (!may_block)
                return ST_BUSY;
            if (count >= MAX_THREADS_DEF)
                return ST_ERROR;
            waiters[(head + count) % MAX_THREADS_DEF] = tid;
            count++;
            return ST_BLOCKED;
        endfunction

        // Advance the shadow state by one accepted request and queue its result
        function void note_request(logic [1:0] cmd, logic [THREAD_W-1:0] tid);
            mutex_result_t r;
            r = '0;
            case (cmd)
                CMD_LOCK:    r.status = grab(tid, 1'b1);
                CMD_TRYLOCK: r.status = grab(tid, 1'b0);
                CMD_UNLOCK: begin
                    if (!held || owner != tid) begin
                        r.status = ST_ERROR;
                    end else if (depth > 0) begin
                        depth--;
                        r.status = ST_NEST_REL;
                    end else if (count > 0) begin
                        owner          = waiters[head];
                        head           = (head + 1) % MAX_THREADS_DEF;
                        count--;
                        r.status       = ST_HANDOVER;
                        r.woken_valid  = 1'b1;
                        r.woken_thread = owner;
                    end else begin
                        held     = 1'b0;
                        owner    = '0;
                        r.status = ST_FREED;
                    end
                end
                default: r.status = ST_ERROR;
            endcase
            r.owner_valid  = held;
            r.owner_thread = held ? owner : '0;
            r.depth_now    = depth;
            pending_results.push_back(r);
        endfunction

        function void check_result(mutex_result_t got);
            mutex_result_t want;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding, status %0d", got.status);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.woken_valid !== want.woken_valid) begin
                $error("woken_valid: expected %0d, got %0d", want.woken_valid, got.woken_valid);
                failures++;
            end
            if (got.woken_thread !== want.woken_thread) begin
                $error("woken_thread: expected %0d, got %0d",
                       want.woken_thread, got.woken_thread);
                failures++;
            end
            if (got.owner_valid !== want.owner_valid) begin
                $error("owner_valid: expected %0d, got %0d", want.owner_valid, got.owner_valid);
                failures++;
            end
            if (got.owner_thread !== want.owner_thread) begin
                $error("owner_thread: expected %0d, got %0d",
                       want.owner_thread, got.owner_thread);
                failures++;
            end
            if (got.depth_now !== want.depth_now) begin
                $error("depth_now: expected %0d, got %0d", want.depth_now, got.depth_now);
                failures++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [1:0]             s_command;
    logic [THREAD_W-1:0]    s_thread_id;
    logic                   m_valid;
    logic                   m_ready;
    logic [2:0]             m_status;
    logic                   m_woken_valid;
    logic [THREAD_W-1:0]    m_woken_thread;
    logic                   m_owner_valid;
    logic [THREAD_W-1:0]    m_owner_thread;
    logic [DEPTH_OUT_W-1:0] m_depth_now;

    mutex_shadow sb;
    // High during phases where neither side idles
    bit          burst = 1'b0;
    int unsigned cycles = 0;

    recursive_mutex_with_wait_queue_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_thread_id    (s_thread_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_woken_valid  (m_woken_valid),
        .m_woken_thread (m_woken_thread),
        .m_owner_valid  (m_owner_valid),
        .m_owner_thread (m_owner_thread),
        .m_depth_now    (m_depth_now)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
    end

    // Idle length: mostly none or short, now and then a long pause
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one request and hold it until the block takes it. Valid is left high
    // on return so that a back-to-back request keeps it up without a dip.
    task automatic issue_request(input logic [1:0] cmd, input logic [THREAD_W-1:0] tid);
        int unsigned gap;
        gap = burst ? 0 : idle_cycles();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_thread_id <= tid;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(cmd, tid);
    endtask

    // Drop valid and hold the sender until every owed result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    // Only ever written with the block idle
    task automatic write_recursive_mode(input bit mode);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.recursive = mode;
    endtask

    // Unlock by whoever holds the mutex until it is free and the queue is empty
    task automatic release_all();
        while (sb.held) issue_request(CMD_UNLOCK, sb.owner);
    endtask

    // Nest one thread to the depth ceiling, push past it, then unwind completely.
    // Needs recursive mode.
    task automatic nest_to_limit(input logic [THREAD_W-1:0] tid);
        release_all();
        issue_request(CMD_LOCK, tid);
        repeat (MAX_DEPTH_DEF) issue_request($urandom_range(0, 1) ? CMD_LOCK : CMD_TRYLOCK, tid);
        // depth overflow, by lock and by trylock
        issue_request(CMD_LOCK, tid);
        issue_request(CMD_TRYLOCK, tid);
        repeat (MAX_DEPTH_DEF + 1) issue_request(CMD_UNLOCK, tid);
    endtask

    // Fill the waiter queue to the brim, then knock on it once more
    task automatic fill_queue();
        logic [THREAD_W-1:0] holder;
        logic [THREAD_W-1:0] tid;
        release_all();
        holder = THREAD_W'($urandom_range(0, 15));
        issue_request(CMD_LOCK, holder);
        repeat (MAX_THREADS_DEF + 1) begin
            do tid = THREAD_W'($urandom_range(0, 15)); while (tid == holder);
            issue_request(CMD_LOCK, tid);
        end
        issue_request(CMD_TRYLOCK, tid);
        issue_request(CMD_LOCK, holder);
        release_all();
    endtask

    // One random request, biased towards the current owner so that nesting,
    // handover and release happen often
    task automatic random_request(input mix_t mix);
        int unsigned         r;
        int unsigned         lock_pct;
        int unsigned         try_pct;
        logic [1:0]          cmd;
        logic [THREAD_W-1:0] tid;
        case (mix)
            MIX_EVEN: begin
                lock_pct = 40;
                try_pct  = 20;
            end
            MIX_LOCKS: begin
                lock_pct = 65;
                try_pct  = 15;
            end
            default: begin
                lock_pct = 20;
                try_pct  = 15;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < 2)
            cmd = CMD_BAD;
        else if (r < 2 + lock_pct)
            cmd = CMD_LOCK;
        else if (r < 2 + lock_pct + try_pct)
            cmd = CMD_TRYLOCK;
        else
            cmd = CMD_UNLOCK;
        if (sb.held && $urandom_range(0, 99) < (cmd == CMD_UNLOCK ? 80 : 35))
            tid = sb.owner;
        else
            tid = THREAD_W'($urandom_range(0, 15));
        issue_request(cmd, tid);
    endtask

    // Result side: take results under random back-pressure and check each one
    initial begin
        mutex_result_t seen;
        int unsigned   stretch;
        bit            ready_now;
        stretch   = 0;
        ready_now = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                seen = {m_status, m_woken_valid, m_woken_thread,
                        m_owner_valid, m_owner_thread, m_depth_now};
                sb.check_result(seen);
            end
            if (burst) begin
                ready_now = 1'b1;
                stretch   = 0;
            end else if (stretch == 0) begin
                ready_now = !ready_now;
                stretch   = ready_now ? $urandom_range(1, 8) : idle_cycles();
            end else begin
                stretch--;
            end
            m_ready <= ready_now;
        end
    end

    // Watchdog
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("recursive_mutex_with_wait_queue_unit_tb NOT OK");
        $finish;
    end

    initial begin
        sb = new;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= 1'b0;
        s_valid     <= 1'b0;
        s_command   <= CMD_LOCK;
        s_thread_id <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks, non-recursive first
        write_recursive_mode(1'b0);
        issue_request(CMD_UNLOCK, 4'd0);     // unlock while free
        issue_request(CMD_BAD, 4'd15);       // unknown command
        issue_request(CMD_TRYLOCK, 4'd15);   // acquire by trylock
        issue_request(CMD_LOCK, 4'd15);      // relock by owner, not recursive
        issue_request(CMD_TRYLOCK, 4'd15);   // trylock by owner fails quietly
        issue_request(CMD_TRYLOCK, 4'd0);    // busy
        issue_request(CMD_UNLOCK, 4'd0);     // unlock by non-owner
        issue_request(CMD_LOCK, 4'd0);
        issue_request(CMD_LOCK, 4'd5);
        issue_request(CMD_LOCK, 4'd0);       // same thread queued twice
        issue_request(CMD_UNLOCK, 4'd15);
        issue_request(CMD_UNLOCK, 4'd0);
        issue_request(CMD_UNLOCK, 4'd5);
        issue_request(CMD_UNLOCK, 4'd0);
        issue_request(CMD_LOCK, 4'd10);

        // Recursive nesting with the mutex still held by thread 10
        write_recursive_mode(1'b1);
        issue_request(CMD_LOCK, 4'd10);
        issue_request(CMD_TRYLOCK, 4'd10);
        issue_request(CMD_BAD, 4'd10);
        issue_request(CMD_UNLOCK, 4'd10);
        issue_request(CMD_UNLOCK, 4'd10);
        issue_request(CMD_UNLOCK, 4'd10);

        // Depth ceiling and full queue
        nest_to_limit(THREAD_W'($urandom_range(0, 15)));
        fill_queue();
        write_recursive_mode(1'b0);
        fill_queue();

        // Random phases, alternating the mode and the command mix
        for (int p = 0; p < 8; p++) begin
            write_recursive_mode(p[0]);
            burst = (p % 3 == 2);
            repeat (75) random_request(mix_t'(p % 3));
        end
        burst = 1'b0;

        drain_results();
        repeat (4) @(posedge aclk);
        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("recursive_mutex_with_wait_queue_unit_tb OK");
        end else begin
            $display("recursive_mutex_with_wait_queue_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
